[src/ecs_pkg.sv]
// Shared types, constants and coefficient decode for the edge convolution stream unit.
// No dependencies; used by the front, the back and the top level.
package ecs_pkg;

   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_KERNEL_SIZE  = 3'd2;
   localparam logic [2:0] CSR_COEF_ROWS_01 = 3'd3;
   localparam logic [2:0] CSR_COEF_ROWS_23 = 3'd4;
   localparam logic [2:0] CSR_COEF_ROW_4   = 3'd5;

   localparam logic [10:0] RESET_WIDTH  = 11'd750;
   localparam logic [10:0] RESET_HEIGHT = 11'd500;

   localparam int MQ_DEPTH  = 4;
   localparam int MQ_CW     = 3;
   localparam int OUT_DEPTH = 8;
   localparam int OUT_CW    = 4;

   localparam logic [17:0] RECIP_50    = 18'd167773;
   localparam int          RECIP_SHIFT = 23;
   localparam int          DIV8_SHIFT  = 3;
   localparam logic signed [15:0] BIAS    = 16'sd128;
   localparam logic signed [15:0] PIX_MAX = 16'sd255;

   typedef struct packed {
      logic [10:0] image_width;
      logic [10:0] image_height;
      logic        kernel_size;
      logic [49:0] coef_rows_01;
      logic [49:0] coef_rows_23;
      logic [24:0] coef_row_4;
   } cfg_type;

   typedef struct packed {
      logic [9:0] col;
      logic [9:0] row;
      logic       last;
   } meta_type;

   typedef struct packed {
      logic [24:0][7:0] win;
      meta_type         meta;
   } item_type;

   typedef struct packed {
      logic [7:0] value;
      meta_type   meta;
   } rsp_type;

   function automatic logic signed [4:0] coef_at(cfg_type cfg, int r, int c);
      logic [49:0] src;
      int          idx;
      if (r < 2) begin
         src = cfg.coef_rows_01;
         idx = r * 5 + c;
      end else if (r < 4) begin
         src = cfg.coef_rows_23;
         idx = (r - 2) * 5 + c;
      end else begin
         src = {25'd0, cfg.coef_row_4};
         idx = c;
      end
      return $signed(src[5 * idx +: 5]);
   endfunction

endpackage

[src/ecs_ram.sv]
// Generic single-write, single-read RAM with registered read-before-write output.
// No dependencies.
module ecs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;
endmodule

[src/ecs_fifo.sv]
// Small register queue with occupancy count.
// No dependencies; used between front and back and at the result side.
module ecs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      count_in = count_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == PW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

   assign rdata = mem_ff[rp_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;
endmodule

[src/ecs_front.sv]
// Front: raster counters, line buffers, 5x5 window; passes interior windows on.
// Depends on ecs_pkg and ecs_ram.
module ecs_front #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_HEIGHT   = 1024,
   parameter int LINE_BUFFERS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ecs_pkg::cfg_type          cfg,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [7:0]                req_pixel_in,
   input  logic [ecs_pkg::MQ_CW-1:0] mq_count,
   output logic                      mq_push,
   output ecs_pkg::item_type         mq_item
);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int LBW   = $clog2(LINE_BUFFERS);
   localparam int WDW   = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
   localparam int HDW   = ($clog2(MAX_HEIGHT + 1) > 11) ? $clog2(MAX_HEIGHT + 1) : 11;
   localparam int MQ_CW = ecs_pkg::MQ_CW;

   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [LBW-1:0] wsel_ff, wsel_in;
   logic           accept;
   logic [WDW-1:0] w, c_ext, iw_ext;
   logic [HDW-1:0] h, r_ext, ih_ext;
   logic [2:0]     k2;
   logic           produce;

   logic                f0_valid_ff;
   logic [7:0]          f0_px_ff;
   logic [RW-1:0]       f0_row_ff;
   logic [LBW-1:0]      f0_wsel_ff;
   logic                f0_prod_ff;
   ecs_pkg::meta_type   f0_meta_ff;

   logic [7:0]          rdata [LINE_BUFFERS];
   logic [24:0][7:0]    win_ff, win_new;
   logic [4:0][7:0]     column;
   logic signed [3:0]   s;

   assign accept   = req_push && !req_full;
   assign req_full = ({1'b0, mq_count} + (MQ_CW + 1)'(f0_valid_ff)) >=
                     (MQ_CW + 1)'(ecs_pkg::MQ_DEPTH);

   always_comb begin
      iw_ext = WDW'(cfg.image_width);
      ih_ext = HDW'(cfg.image_height);
      w = (iw_ext < WDW'(3)) ? WDW'(3) :
          (iw_ext > WDW'(MAX_WIDTH)) ? WDW'(MAX_WIDTH) : iw_ext;
      h = (ih_ext < HDW'(3)) ? HDW'(3) :
          (ih_ext > HDW'(MAX_HEIGHT)) ? HDW'(MAX_HEIGHT) : ih_ext;
      c_ext = WDW'(col_ff);
      r_ext = HDW'(row_ff);
      k2 = cfg.kernel_size ? 3'd4 : 3'd2;
      produce = (c_ext < w) && (r_ext < h) && (c_ext >= WDW'(k2)) && (r_ext >= HDW'(k2));

      col_in  = col_ff;
      row_in  = row_ff;
      wsel_in = wsel_ff;
      if ((c_ext + 1'b1) >= w) begin
         col_in = '0;
         if ((r_ext + 1'b1) >= h) begin
            row_in  = '0;
            wsel_in = '0;
         end else begin
            row_in  = row_ff + 1'b1;
            wsel_in = (wsel_ff == LBW'(LINE_BUFFERS - 1)) ? '0 : wsel_ff + 1'b1;
         end
      end else begin
         col_in = col_ff + 1'b1;
         if (r_ext >= h) begin
            row_in  = '0;
            wsel_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         wsel_ff     <= '0;
         f0_valid_ff <= 1'b0;
      end else begin
         f0_valid_ff <= accept;
         if (accept) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            wsel_ff <= wsel_in;
         end
      end
      if (accept) begin
         f0_px_ff        <= req_pixel_in;
         f0_row_ff       <= row_ff;
         f0_wsel_ff      <= wsel_ff;
         f0_prod_ff      <= produce;
         f0_meta_ff.col  <= 10'(c_ext - WDW'(k2 >> 1));
         f0_meta_ff.row  <= 10'(r_ext - HDW'(k2 >> 1));
         f0_meta_ff.last <= (c_ext == w - 1'b1) && (r_ext == h - 1'b1);
      end
   end

   for (genvar i = 0; i < LINE_BUFFERS; i++) begin : g_line
      ecs_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line (
         .clock (clock),
         .we    (accept && (wsel_ff == LBW'(i))),
         .waddr (col_ff),
         .wdata (req_pixel_in),
         .re    (accept),
         .raddr (col_ff),
         .rdata (rdata[i])
      );
   end

   always_comb begin
      column[4] = f0_px_ff;
      for (int d = 1; d <= 4; d++) begin
         s = $signed(4'(f0_wsel_ff)) - $signed(4'(d));
         if (s < 0) begin
            s = s + 4'(LINE_BUFFERS);
         end
         if (s < 0) begin
            s = s + 4'(LINE_BUFFERS);
         end
         column[4 - d] = (f0_row_ff >= RW'(d)) ? rdata[LBW'(s)] : 8'd0;
      end
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 4; c++) begin
            win_new[r * 5 + c] = win_ff[r * 5 + c + 1];
         end
         win_new[r * 5 + 4] = column[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (f0_valid_ff) begin
         win_ff <= win_new;
      end
   end

   assign mq_push      = f0_valid_ff && f0_prod_ff;
   assign mq_item.win  = win_new;
   assign mq_item.meta = f0_meta_ff;
endmodule

[src/ecs_back.sv]
// Back: multiply-accumulate, scale by 8 or 50, bias and clip, result queue.
// Depends on ecs_pkg and ecs_fifo.
module ecs_back (
   input  logic              clock,
   input  logic              reset,
   input  ecs_pkg::cfg_type  cfg,
   input  logic              mq_empty,
   input  ecs_pkg::item_type mq_item,
   output logic              mq_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ecs_pkg::rsp_type  rsp_word
);
   logic [3:0]               v_ff;
   ecs_pkg::meta_type        m_ff [4];
   logic signed [13:0]       prod_ff [25];
   logic signed [13:0]       prod_in [25];
   logic signed [15:0]       rsum_ff [5];
   logic signed [15:0]       rsum_in [5];
   logic signed [17:0]       total;
   logic [16:0]              abs_ff, abs3_ff;
   logic                     neg_ff, neg3_ff;
   logic [34:0]              mprod_ff;
   logic [13:0]              q;
   logic signed [15:0]       res;
   ecs_pkg::rsp_type         push_word;
   logic [ecs_pkg::OUT_CW-1:0] ocount;
   logic [ecs_pkg::OUT_CW:0]   occ;

   assign occ = {1'b0, ocount} + (ecs_pkg::OUT_CW + 1)'($countones(v_ff));
   assign mq_pop = !mq_empty && (occ < (ecs_pkg::OUT_CW + 1)'(ecs_pkg::OUT_DEPTH));

   always_comb begin
      logic [7:0]         px;
      logic signed [4:0]  cf;
      int                 alt;
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 5; c++) begin
            alt = (r >= 1 && r <= 3 && c >= 1 && c <= 3) ? (r + 1) * 5 + c + 1 : 0;
            cf  = ecs_pkg::coef_at(cfg, r, c);
            if (cfg.kernel_size) begin
               px = mq_item.win[r * 5 + c];
            end else if (r >= 1 && r <= 3 && c >= 1 && c <= 3) begin
               px = mq_item.win[alt];
            end else begin
               px = 8'd0;
            end
            prod_in[r * 5 + c] = $signed({1'b0, px}) * cf;
         end
      end
      for (int r = 0; r < 5; r++) begin
         rsum_in[r] = 16'(prod_ff[r * 5]) + 16'(prod_ff[r * 5 + 1]) + 16'(prod_ff[r * 5 + 2])
                    + 16'(prod_ff[r * 5 + 3]) + 16'(prod_ff[r * 5 + 4]);
      end
      total = 18'(rsum_ff[0]) + 18'(rsum_ff[1]) + 18'(rsum_ff[2])
            + 18'(rsum_ff[3]) + 18'(rsum_ff[4]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], mq_pop};
      end
      m_ff[0] <= mq_item.meta;
      for (int i = 1; i < 4; i++) begin
         m_ff[i] <= m_ff[i - 1];
      end
      prod_ff <= prod_in;
      rsum_ff <= rsum_in;
      neg_ff  <= total < 0;
      abs_ff  <= (total < 0) ? 17'(-total) : 17'(total);
      neg3_ff  <= neg_ff;
      abs3_ff  <= abs_ff;
      mprod_ff <= 35'(abs_ff) * 35'(ecs_pkg::RECIP_50);
   end

   always_comb begin
      q = cfg.kernel_size ? 14'(mprod_ff[34:ecs_pkg::RECIP_SHIFT])
                          : 14'(abs3_ff >> ecs_pkg::DIV8_SHIFT);
      res = neg3_ff ? ecs_pkg::BIAS + $signed({2'b0, q}) : ecs_pkg::BIAS - $signed({2'b0, q});
      priority if (res < 0) begin
         push_word.value = 8'd0;
      end else if (res > ecs_pkg::PIX_MAX) begin
         push_word.value = 8'd255;
      end else begin
         push_word.value = res[7:0];
      end
      push_word.meta = m_ff[3];
   end

   ecs_fifo #(.WIDTH($bits(ecs_pkg::rsp_type)), .DEPTH(ecs_pkg::OUT_DEPTH)) u_out (
      .clock (clock),
      .reset (reset),
      .push  (v_ff[3]),
      .wdata (push_word),
      .pop   (rsp_pop && !rsp_empty),
      .rdata (rsp_word),
      .empty (rsp_empty),
      .count (ocount)
   );
endmodule

[src/edge_convolution_3x3_5x5_stream_unit.sv]
// Edge convolution stream unit, 3x3 or 5x5 kernel over 8-bit grey pixels.
// A result passes the line RAM read, window queue, product, row sum, total and
// divide registers before it reaches the result queue.
// Throughput: one pixel per cycle, one read per line RAM and one write to the selected line RAM per pixel;
// the input stalls only when the window queue or the result queue backs up.
// Reset: synchronous; clears counters, window and queues and sets the configuration registers to defaults.
module edge_convolution_3x3_5x5_stream_unit #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_HEIGHT   = 1024,
   parameter int LINE_BUFFERS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_pixel_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_filtered_value,
   output logic [9:0]  rsp_center_col,
   output logic [9:0]  rsp_center_row,
   output logic        rsp_frame_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [49:0] csr_wdata
);
   ecs_pkg::cfg_type  cfg_ff;
   logic              mq_push, mq_pop, mq_empty;
   logic [ecs_pkg::MQ_CW-1:0] mq_count;
   ecs_pkg::item_type mq_witem, mq_ritem;
   ecs_pkg::rsp_type  rsp_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= ecs_pkg::RESET_WIDTH;
         cfg_ff.image_height <= ecs_pkg::RESET_HEIGHT;
         cfg_ff.kernel_size  <= 1'b0;
         cfg_ff.coef_rows_01 <= '0;
         cfg_ff.coef_rows_23 <= '0;
         cfg_ff.coef_row_4   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ecs_pkg::CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata[10:0];
            ecs_pkg::CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata[10:0];
            ecs_pkg::CSR_KERNEL_SIZE:  cfg_ff.kernel_size  <= csr_wdata[0];
            ecs_pkg::CSR_COEF_ROWS_01: cfg_ff.coef_rows_01 <= csr_wdata;
            ecs_pkg::CSR_COEF_ROWS_23: cfg_ff.coef_rows_23 <= csr_wdata;
            ecs_pkg::CSR_COEF_ROW_4:   cfg_ff.coef_row_4   <= csr_wdata[24:0];
            default: begin
            end
         endcase
      end
   end

   ecs_front #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .LINE_BUFFERS (LINE_BUFFERS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_pixel_in (req_pixel_in),
      .mq_count     (mq_count),
      .mq_push      (mq_push),
      .mq_item      (mq_witem)
   );

   ecs_fifo #(.WIDTH($bits(ecs_pkg::item_type)), .DEPTH(ecs_pkg::MQ_DEPTH)) u_mq (
      .clock (clock),
      .reset (reset),
      .push  (mq_push),
      .wdata (mq_witem),
      .pop   (mq_pop),
      .rdata (mq_ritem),
      .empty (mq_empty),
      .count (mq_count)
   );

   ecs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mq_empty  (mq_empty),
      .mq_item   (mq_ritem),
      .mq_pop    (mq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   assign rsp_filtered_value = rsp_word.value;
   assign rsp_center_col     = rsp_word.meta.col;
   assign rsp_center_row     = rsp_word.meta.row;
   assign rsp_frame_last     = rsp_word.meta.last;

   a_mq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      mq_push |-> (mq_count < ecs_pkg::MQ_CW'(ecs_pkg::MQ_DEPTH)) || mq_pop)
      else $error("window queue overflow");

   a_mq_no_underflow: assert property (@(posedge clock) disable iff (reset)
      mq_pop |-> !mq_empty)
      else $error("window queue underflow");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");
endmodule
